// ----- src/dqsa_pkg.sv -----
// package for the double-ended queue with search and average
// holds action and status codes, field widths and the divider result type
// no dependencies
package dqsa_pkg;

	localparam int ACT_W  = 3;
	localparam int STAT_W = 2;
	localparam int DATA_W = 32;
	localparam int POS_W  = 8;
	localparam int OCC_W  = 9;

	localparam logic [ACT_W-1:0] ACT_APPEND = 3'd0;
	localparam logic [ACT_W-1:0] ACT_POP_FRONT = 3'd1;
	localparam logic [ACT_W-1:0] ACT_POP_REAR = 3'd2;
	localparam logic [ACT_W-1:0] ACT_SEARCH = 3'd3;
	localparam logic [ACT_W-1:0] ACT_COUNT = 3'd4;
	localparam logic [ACT_W-1:0] ACT_MEAN = 3'd5;

	localparam logic [STAT_W-1:0] ST_OK = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [STAT_W-1:0] ST_FULL = 2'd3;

	typedef struct packed {
		logic done;
		logic signed [DATA_W-1:0] quot;
	} div_res_t;

endpackage

// ----- src/dqsa_ram.sv -----
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module dqsa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic clk,
	input  logic we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- src/dqsa_div.sv -----
// serial restoring divider, one quotient bit per cycle
// signed magnitude in, truncated signed quotient out; uses dqsa_pkg
module dqsa_div #(
	parameter int SW = 41,
	parameter int CW = 9
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic neg,
	input  logic [SW-1:0] mag,
	input  logic [CW-1:0] divisor,
	output dqsa_pkg::div_res_t res
);

	import dqsa_pkg::*;

	localparam int NW = $clog2(SW + 1);

	logic busy_q;
	logic done_q;
	logic neg_q;
	logic [NW-1:0] cnt_q;
	logic [CW-1:0] rem_q;
	logic [SW-1:0] quot_q;
	logic [CW-1:0] div_q;
	logic [CW:0] shifted;
	logic [CW:0] diff;

	assign shifted = {rem_q, quot_q[SW-1]};
	assign diff = shifted - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= NW'(SW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == NW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= mag;
			rem_q <= '0;
			div_q <= divisor;
			neg_q <= neg;
		end else if (busy_q) begin
			if (!diff[CW]) begin
				rem_q <= diff[CW-1:0];
				quot_q <= {quot_q[SW-2:0], 1'b1};
			end else begin
				rem_q <= shifted[CW-1:0];
				quot_q <= {quot_q[SW-2:0], 1'b0};
			end
		end
	end

	assign res.done = done_q;
	assign res.quot = neg_q ? -quot_q[DATA_W-1:0] : quot_q[DATA_W-1:0];

endmodule

// ----- src/deque_with_search_and_average.sv -----
// top level of the double-ended queue with search and running average
// uses dqsa_pkg, dqsa_ram and dqsa_div
//
// channel   dir  width  content
// s_*       in   40     action [2:0], operand [34:3]
// m_*       out  56     status [1:0], position [9:2], occupancy [18:10], mean_value [50:19]
//
// an item that leaves the queue nonempty ends in a serial division of the running sum by the count,
// over SW = 32 + clog2(DEPTH+1) quotient bits (41 at DEPTH 256)
// search compares one entry per cycle through the ram read port
// reset clears head, count and sum at once; the entry ram is not cleared
// s_tready is high only while idle; a finished item waits while the output register is full
module deque_with_search_and_average #(
	parameter int DEPTH = 256
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [39:0] s_tdata,   // action, operand
	output logic m_tvalid,
	input  logic m_tready,
	output logic [55:0] m_tdata    // status, position, occupancy, mean_value
);

	import dqsa_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = DATA_W + CW;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_WR = 3'd1;
	localparam logic [2:0] S_RD = 3'd2;
	localparam logic [2:0] S_UPD = 3'd3;
	localparam logic [2:0] S_SRCH = 3'd4;
	localparam logic [2:0] S_DIVGO = 3'd5;
	localparam logic [2:0] S_DIVW = 3'd6;
	localparam logic [2:0] S_DONE = 3'd7;

	logic [2:0] state_q;
	logic [PW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic signed [SW-1:0] sum_q;
	logic [ACT_W-1:0] act_q;
	logic signed [DATA_W-1:0] key_q;
	logic [CW-1:0] issue_q;
	logic rd_vld_q;
	logic [PW-1:0] rd_off_q;
	logic [STAT_W-1:0] status_q;
	logic [PW-1:0] pos_q;
	logic signed [DATA_W-1:0] mean_q;
	logic tvalid_q;
	logic [55:0] tdata_q;

	logic [ACT_W-1:0] in_act;
	logic signed [DATA_W-1:0] in_operand;
	logic accept;
	logic [PW:0] slot_sum;
	logic [PW-1:0] slot;
	logic [PW-1:0] head_next;
	logic ram_we;
	logic signed [DATA_W-1:0] rdata;
	logic div_start;
	logic [SW-1:0] div_mag;
	div_res_t div_res;

	assign in_act = s_tdata[2:0];
	assign in_operand = s_tdata[34:3];
	assign s_tready = (state_q == S_IDLE);
	assign accept = s_tvalid && s_tready;

	// circular slot of head plus offset
	assign slot_sum = (PW+1)'(head_q) + (PW+1)'(issue_q[PW-1:0]);
	assign slot = (slot_sum >= (PW+1)'(DEPTH)) ? PW'(slot_sum - (PW+1)'(DEPTH))
		: slot_sum[PW-1:0];
	assign head_next = (head_q == PW'(DEPTH - 1)) ? '0 : head_q + 1'b1;

	assign ram_we = (state_q == S_WR);
	assign div_start = (state_q == S_DIVGO) && (count_q != '0);
	assign div_mag = sum_q[SW-1] ? SW'(-sum_q) : SW'(sum_q);

	dqsa_ram #(
		.WIDTH(DATA_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(slot),
		.wdata(key_q),
		.raddr(slot),
		.rdata(rdata)
	);

	dqsa_div #(
		.SW(SW),
		.CW(CW)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.neg(sum_q[SW-1]),
		.mag(div_mag),
		.divisor(count_q),
		.res(div_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q <= '0;
			count_q <= '0;
			sum_q <= '0;
			rd_vld_q <= 1'b0;
			tvalid_q <= 1'b0;
		end else begin
			if (m_tready && (state_q != S_DONE)) begin
				tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						status_q <= ST_OK;
						pos_q <= '0;
						issue_q <= '0;
						rd_vld_q <= 1'b0;
						unique case (in_act) inside
							ACT_APPEND: begin
								issue_q <= count_q;
								if (count_q == CW'(DEPTH)) begin
									status_q <= ST_FULL;
									state_q <= S_DIVGO;
								end else begin
									state_q <= S_WR;
								end
							end
							ACT_POP_FRONT, ACT_POP_REAR: begin
								if (in_act == ACT_POP_REAR) begin
									issue_q <= count_q - 1'b1;
								end
								if (count_q == '0) begin
									status_q <= ST_EMPTY;
									state_q <= S_DIVGO;
								end else begin
									state_q <= S_RD;
								end
							end
							ACT_SEARCH: begin
								state_q <= S_SRCH;
							end
							default: begin
								state_q <= S_DIVGO;
							end
						endcase
					end
				end
				S_WR: begin
					count_q <= count_q + 1'b1;
					sum_q <= sum_q + SW'(key_q);
					state_q <= S_DIVGO;
				end
				S_RD: begin
					state_q <= S_UPD;
				end
				S_UPD: begin
					sum_q <= sum_q - SW'(rdata);
					count_q <= count_q - 1'b1;
					if (act_q == ACT_POP_FRONT) begin
						head_q <= head_next;
					end
					state_q <= S_DIVGO;
				end
				S_SRCH: begin
					if (rd_vld_q && (rdata == key_q)) begin
						pos_q <= rd_off_q;
						rd_vld_q <= 1'b0;
						state_q <= S_DIVGO;
					end else if ((issue_q == count_q) && !rd_vld_q) begin
						status_q <= ST_NOT_FOUND;
						state_q <= S_DIVGO;
					end else begin
						rd_vld_q <= (issue_q != count_q);
						rd_off_q <= issue_q[PW-1:0];
						if (issue_q != count_q) begin
							issue_q <= issue_q + 1'b1;
						end
					end
				end
				S_DIVGO: begin
					if (count_q == '0) begin
						mean_q <= '0;
						state_q <= S_DONE;
					end else begin
						state_q <= S_DIVW;
					end
				end
				S_DIVW: begin
					if (div_res.done) begin
						mean_q <= div_res.quot;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!tvalid_q || m_tready) begin
						tdata_q <= {5'd0, mean_q, OCC_W'(count_q), POS_W'(pos_q), status_q};
						tvalid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q <= in_act;
			key_q <= in_operand;
		end
	end

	assign m_tvalid = tvalid_q;
	assign m_tdata = tdata_q;

endmodule

// ----- src/dqsa_checker.sv -----
// port-level checks for the double-ended queue with search and average
// uses dqsa_pkg; bound to deque_with_search_and_average below
module dqsa_checker #(
	parameter int DEPTH = 256
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic m_tvalid,
	input logic m_tready,
	input logic [55:0] m_tdata
);

	import dqsa_pkg::*;

	localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(DEPTH);

	logic [STAT_W-1:0] status;
	logic [POS_W-1:0] position;
	logic [OCC_W-1:0] occupancy;
	logic [DATA_W-1:0] mean_value;

	assign status = m_tdata[1:0];
	assign position = m_tdata[9:2];
	assign occupancy = m_tdata[18:10];
	assign mean_value = m_tdata[50:19];

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while an item is in work");

	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (status == ST_FULL) |-> occupancy == FULL_OCC)
		else $error("full flagged with wrong occupancy");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (status == ST_EMPTY) |-> occupancy == '0 && mean_value == '0)
		else $error("empty flagged with nonzero occupancy or mean");

	a_miss_pos: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (status == ST_NOT_FOUND) |-> position == '0)
		else $error("not found with nonzero position");

endmodule

bind deque_with_search_and_average dqsa_checker #(.DEPTH(DEPTH)) u_dqsa_checker (.*);
